@@ design/sif_pkg.sv @@
// ============================================================================
// sif_pkg
// Types and constants shared by the singleton index filter modules.
// ============================================================================
package sif_pkg;

  // Counter table addressing and row numbering
  localparam int unsigned INDEX_BITS = 20;
  localparam int unsigned ROW_BITS   = 24;
  localparam int unsigned TABLE_DEPTH = 2 ** INDEX_BITS;

  // Fixed payload widths
  localparam int unsigned IDX_FIELD_W = 20;
  localparam int unsigned ROW_FIELD_W = 24;

  localparam int unsigned CNT_W = 2;

  typedef logic [INDEX_BITS-1:0] addr_t;
  typedef logic [ROW_BITS-1:0]   row_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  // Saturation point and singleton value of a counter
  localparam cnt_t COUNT_SAT = 2'd2;
  localparam cnt_t COUNT_ONE = 2'd1;
  localparam cnt_t COUNT_ZERO = 2'd0;

  typedef enum logic [1:0] {
    OP_COUNT = 2'd0,
    OP_CHECK = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  typedef struct packed {
    logic [1:0]             operation;
    logic [IDX_FIELD_W-1:0] entry_index;
    logic                   entry_invalid;
    logic                   row_last;
  } in_item_t;

  typedef struct packed {
    logic [ROW_FIELD_W-1:0] row_number;
    logic                   remove_row;
  } out_item_t;

  // Clearing sweep status
  typedef struct packed {
    logic  active;
    addr_t addr;
  } sweep_t;

  // Take the low INDEX_BITS bits of an index field, zero-extending if needed
  function automatic addr_t idx_to_addr(logic [IDX_FIELD_W-1:0] v);
    logic [INDEX_BITS+IDX_FIELD_W-1:0] w;
    w = {{INDEX_BITS{1'b0}}, v};
    return w[INDEX_BITS-1:0];
  endfunction

  // Fit a row count to the output field width
  function automatic logic [ROW_FIELD_W-1:0] row_to_field(row_t v);
    logic [ROW_BITS+ROW_FIELD_W-1:0] w;
    w = {{ROW_FIELD_W{1'b0}}, v};
    return w[ROW_FIELD_W-1:0];
  endfunction

endpackage

@@ design/sif_ram.sv @@
// ============================================================================
// sif_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module sif_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/sif_sweep.sv @@
// ============================================================================
// sif_sweep
// Clearing sequencer: zero the counter table one entry per cycle.
// ============================================================================
module sif_sweep (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  output sif_pkg::sweep_t sweep_o
);

  logic           active_q, active_d;
  sif_pkg::addr_t addr_q, addr_d;

  always_comb begin
    active_d = active_q;
    addr_d   = addr_q;
    if (active_q) begin
      addr_d = addr_q + 1'b1;
      // stop after the last entry
      if (&addr_q) begin
        active_d = 1'b0;
      end
    end else if (start_i) begin
      active_d = 1'b1;
      addr_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b1;
      addr_q   <= '0;
    end else begin
      active_q <= active_d;
      addr_q   <= addr_d;
    end
  end

  assign sweep_o.active = active_q;
  assign sweep_o.addr   = addr_q;

endmodule

@@ design/singleton_index_filter.sv @@
// ============================================================================
// singleton_index_filter
// Counts index occurrences in a 2-bit saturating counter table and flags
// rows that hold a singleton or invalid index.
// ============================================================================
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+---------------------------
//   in      | input     | in_valid_i/stall_o | sif_pkg::in_item_t
//   out     | output    | out_valid_o/stall_i| sif_pkg::out_item_t
//
// One item per cycle in steady state with no stall: an item is accepted,
// its counter is read from the table RAM into registered read data, and
// the update stage updates the counter and the row state. A count right
// after a count of the same index is forwarded around the RAM.
// Reset and every clear item start a sweep that zeroes all 2**INDEX_BITS
// table entries, one entry per cycle; no item is accepted meanwhile.
// A clear item also holds off the next item until its sweep has begun.
// A finished row waits in the output register; while it is stalled the
// next row end holds in the update stage and the input stalls.
// ============================================================================
module singleton_index_filter (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  sif_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sif_pkg::out_item_t out_item_o
);

  // --------------------------------------------------------------------------
  // Update stage registers
  // --------------------------------------------------------------------------
  logic              s1_valid_q;
  sif_pkg::in_item_t s1_item_q;
  logic              fwd_q;
  sif_pkg::cnt_t     fwd_cnt_q;

  // Row state
  sif_pkg::row_t row_cnt_q, row_cnt_d;
  logic          row_flag_q, row_flag_d;

  // Output register
  logic               out_valid_q;
  sif_pkg::out_item_t out_item_q;

  sif_pkg::sweep_t sweep;
  sif_pkg::cnt_t   rd_cnt;
  sif_pkg::cnt_t   old_cnt;
  sif_pkg::cnt_t   new_cnt;
  sif_pkg::addr_t  in_addr;
  sif_pkg::addr_t  s1_addr;

  logic in_accept;
  logic s1_write;
  logic s1_result;
  logic s1_clear;
  logic s1_advance;
  logic out_load;
  logic mark;
  logic flag;

  logic          ram_we;
  sif_pkg::addr_t ram_waddr;
  sif_pkg::cnt_t  ram_wdata;

  assign in_addr = sif_pkg::idx_to_addr(in_item_i.entry_index);
  assign s1_addr = sif_pkg::idx_to_addr(s1_item_q.entry_index);

  // --------------------------------------------------------------------------
  // Update stage: pick the counter value and compute its successor
  // --------------------------------------------------------------------------
  // take the forwarded count when the previous item wrote this entry
  assign old_cnt = fwd_q ? fwd_cnt_q : rd_cnt;
  // saturate at two
  assign new_cnt = (old_cnt >= sif_pkg::COUNT_SAT) ? old_cnt : old_cnt + 1'b1;

  assign s1_write = s1_valid_q && (s1_item_q.operation == sif_pkg::OP_COUNT)
                    && !s1_item_q.entry_invalid;
  assign s1_result = s1_valid_q && (s1_item_q.operation == sif_pkg::OP_CHECK)
                     && s1_item_q.row_last;
  assign s1_clear = s1_valid_q && (s1_item_q.operation == sif_pkg::OP_CLEAR);

  // invalid entries mark the row without looking at the counter
  assign mark = s1_item_q.entry_invalid || (old_cnt == sif_pkg::COUNT_ONE);
  assign flag = row_flag_q || mark;

  // the output register takes a new row when empty or being drained
  assign out_load   = !out_valid_q || !out_stall_i;
  assign s1_advance = !s1_result || out_load;

  // hold input during a sweep, behind a clear, or behind a blocked row end
  assign in_stall_o = sweep.active || s1_clear || (s1_valid_q && !s1_advance);
  assign in_accept  = in_valid_i && !in_stall_o;

  // --------------------------------------------------------------------------
  // Counter table
  // --------------------------------------------------------------------------
  assign ram_we    = sweep.active || s1_write;
  assign ram_waddr = sweep.active ? sweep.addr : s1_addr;
  assign ram_wdata = sweep.active ? sif_pkg::COUNT_ZERO : new_cnt;

  sif_ram #(
    .WIDTH (sif_pkg::CNT_W),
    .DEPTH (sif_pkg::TABLE_DEPTH)
  ) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (in_accept),
    .raddr_i (in_addr),
    .rdata_o (rd_cnt)
  );

  sif_sweep u_sweep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (s1_clear),
    .sweep_o (sweep)
  );

  // --------------------------------------------------------------------------
  // Row state
  // --------------------------------------------------------------------------
  always_comb begin
    row_cnt_d  = row_cnt_q;
    row_flag_d = row_flag_q;
    if (s1_clear) begin
      row_cnt_d  = '0;
      row_flag_d = 1'b0;
    end else if (s1_valid_q && (s1_item_q.operation == sif_pkg::OP_CHECK)
                 && s1_advance) begin
      if (s1_item_q.row_last) begin
        row_cnt_d  = row_cnt_q + 1'b1;
        row_flag_d = 1'b0;
      end else begin
        row_flag_d = flag;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_q       <= 1'b0;
      row_cnt_q   <= '0;
      row_flag_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      row_cnt_q  <= row_cnt_d;
      row_flag_q <= row_flag_d;
      if (in_accept) begin
        s1_valid_q <= 1'b1;
        // the RAM read just issued misses this cycle's write: forward it
        fwd_q      <= s1_write && (s1_addr == in_addr);
      end else if (s1_advance) begin
        s1_valid_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= s1_result;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_item_q <= in_item_i;
      fwd_cnt_q <= new_cnt;
    end
    if (out_load && s1_result) begin
      out_item_q.row_number <= sif_pkg::row_to_field(row_cnt_q);
      out_item_q.remove_row <= flag;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_no_accept_in_sweep: assert property (
    @(posedge clk_i) disable iff (!rst_ni) !(sweep.active && in_accept)
  ) else $error("item accepted during clearing sweep");

  a_sweep_write_excl: assert property (
    @(posedge clk_i) disable iff (!rst_ni) !(sweep.active && s1_write)
  ) else $error("counter write collides with clearing sweep");

  a_row_end_lands: assert property (
    @(posedge clk_i) disable iff (!rst_ni) (s1_result && s1_advance) |=> out_valid_o
  ) else $error("finished row not presented at output");

  a_forward_set: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      (in_accept && s1_write && (s1_addr == in_addr)) |=> fwd_q
  ) else $error("missing forward on back-to-back count of one index");

endmodule

@@ sim/tb_singleton_index_filter.sv @@
`timescale 1ns / 100ps
// ============================================================================
// tb_singleton_index_filter
// Self-checking testbench for the singleton index filter. A queue of entries
// (directed corner cases, then count/check row passes with random content,
// noise and broken sequences) feeds a clocked driver. A clocked monitor
// tracks the counter table and row state on every accepted item and compares
// each finished row against the oldest prediction.
// ============================================================================
module tb_singleton_index_filter;

  // Index field as carried in an input item
  typedef logic [sif_pkg::IDX_FIELD_W-1:0] idx_t;

  // Operation code the block must ignore
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int IDLE_PCT = 25;
  localparam int MAX_REPORTS = 10;
  localparam int RANDOM_ITEMS = 550;
  localparam int DRAIN_CYCLES = 20;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  sif_pkg::in_item_t  in_item_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  sif_pkg::out_item_t out_item_o;

  singleton_index_filter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  always #5 clk_i = ~clk_i;

  // Entries waiting to be driven, and finished rows waiting to come out
  sif_pkg::in_item_t  entry_queue [$];
  sif_pkg::out_item_t pending_rows [$];

  // Tracked copy of the block state
  sif_pkg::cnt_t count_tbl [int unsigned];
  sif_pkg::row_t row_seq;
  logic          row_mark;

  int   stim_items;
  int   items_taken;
  int   clears_taken;
  int   rows_seen;
  int   rows_removed;
  int   mismatches;
  logic in_fire = 1'b0;
  logic quiet;

  // Hold both sides free of idling for a stretch in the middle of the run
  assign quiet = (items_taken >= 200) && (items_taken < 330);

  // --------------------------------------------------------------------------
  // Prediction: apply one accepted entry to the tracked state, and queue the
  // finished row when a check entry closes one.
  // --------------------------------------------------------------------------
  function automatic sif_pkg::cnt_t count_of(sif_pkg::addr_t a);
    if (count_tbl.exists(int'(a))) return count_tbl[int'(a)];
    return sif_pkg::COUNT_ZERO;
  endfunction

  function automatic void track_entry(sif_pkg::in_item_t it);
    sif_pkg::addr_t     a;
    sif_pkg::cnt_t      c;
    logic               flag;
    sif_pkg::out_item_t row;
    // Only the low INDEX_BITS of the index address the table
    a = sif_pkg::addr_t'(it.entry_index);
    case (it.operation)
      sif_pkg::OP_COUNT: begin
        // Invalid entries leave the table alone
        if (!it.entry_invalid) begin
          c = count_of(a);
          if (c < sif_pkg::COUNT_SAT) c = c + 1'b1;
          count_tbl[int'(a)] = c;
        end
      end
      sif_pkg::OP_CHECK: begin
        // An invalid entry marks the row without looking at its counter
        flag = row_mark || it.entry_invalid || (count_of(a) == sif_pkg::COUNT_ONE);
        if (it.row_last) begin
          row.row_number = row_seq;
          row.remove_row = flag;
          pending_rows.push_back(row);
          row_seq = row_seq + 1'b1;
          row_mark = 1'b0;
        end else begin
          row_mark = flag;
        end
      end
      sif_pkg::OP_CLEAR: begin
        count_tbl.delete();
        row_seq = '0;
        row_mark = 1'b0;
        clears_taken++;
      end
      default: ;  // unused code: drop without effect
    endcase
  endfunction

  function automatic void report_row(string what, sif_pkg::out_item_t want,
                                     sif_pkg::out_item_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("ERROR @%0t: %s: expected row %0d remove %0b, got row %0d remove %0b",
               $realtime, what, want.row_number, want.remove_row,
               got.row_number, got.remove_row);
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: check results first, then track the item accepted at this edge.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    sif_pkg::out_item_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        rows_seen++;
        if (out_item_o.remove_row) rows_removed++;
        if (pending_rows.size() == 0) begin
          report_row("row with nothing pending", '0, out_item_o);
        end else begin
          want = pending_rows.pop_front();
          if (out_item_o.row_number !== want.row_number ||
              out_item_o.remove_row !== want.remove_row)
            report_row("row result differs", want, out_item_o);
        end
      end
      if (in_valid_i && !in_stall_o) begin
        track_entry(in_item_i);
        items_taken++;
      end
    end
    in_fire <= rst_ni && in_valid_i && !in_stall_o;
  end

  // --------------------------------------------------------------------------
  // Driver: advance to the next entry once the current one is taken, hold a
  // stalled entry, and idle or stall at random outside the quiet stretch.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_fire) begin
        if (entry_queue.size() != 0 && (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
          in_item_i  <= entry_queue.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus builders
  // --------------------------------------------------------------------------
  task automatic push_entry(logic [1:0] op, idx_t idx, logic bad, logic last);
    sif_pkg::in_item_t it;
    it.operation     = op;
    it.entry_index   = idx;
    it.entry_invalid = bad;
    it.row_last      = last;
    entry_queue.push_back(it);
    if (op != OP_UNUSED) stim_items++;
  endtask

  // Count a few rows, then check the same rows: the usual filter pass
  task automatic add_row_pass();
    idx_t pool [6];
    idx_t ents [$];
    logic bads [$];
    logic ends [$];
    int   len;
    int   nrows;
    nrows = $urandom_range(1, 6);
    // Sometimes reuse a tiny index range so counts carry over between passes
    foreach (pool[i])
      pool[i] = ($urandom_range(0, 3) == 0) ? idx_t'($urandom_range(0, 63))
                                            : idx_t'($urandom);
    for (int r = 0; r < nrows; r++) begin
      len = $urandom_range(1, 4);
      for (int e = 0; e < len; e++) begin
        ents.push_back(pool[$urandom_range(0, 5)]);
        bads.push_back($urandom_range(0, 11) == 0);
        ends.push_back(e == len - 1);
      end
    end
    foreach (ents[i]) push_entry(sif_pkg::OP_COUNT, ents[i], bads[i], ends[i]);
    // Extra counts push some indices past a single occurrence
    repeat ($urandom_range(0, 3))
      push_entry(sif_pkg::OP_COUNT, pool[$urandom_range(0, 5)], 1'b0, 1'b0);
    foreach (ents[i]) push_entry(sif_pkg::OP_CHECK, ents[i], bads[i], ends[i]);
  endtask

  // Unstructured entries over the full field ranges, unused code included
  task automatic add_noise();
    logic [1:0] op;
    repeat ($urandom_range(1, 6)) begin
      case ($urandom_range(0, 9))
        0:       op = OP_UNUSED;
        1, 2, 3: op = sif_pkg::OP_CHECK;
        default: op = sif_pkg::OP_COUNT;
      endcase
      push_entry(op, idx_t'($urandom), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)));
    end
  endtask

  // A check row left open while counts interleave; the gathered mark must stick
  task automatic add_open_row();
    idx_t idx;
    idx = idx_t'($urandom);
    push_entry(sif_pkg::OP_COUNT, idx, 1'b0, 1'b0);
    push_entry(sif_pkg::OP_CHECK, idx, 1'b0, 1'b0);
    push_entry(sif_pkg::OP_CHECK, idx_t'($urandom), 1'($urandom_range(0, 1)), 1'b0);
    push_entry(sif_pkg::OP_COUNT, idx, 1'b0, 1'b1);
    push_entry(sif_pkg::OP_CHECK, idx, 1'b0, 1'b1);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic mid_clear_done;
    row_seq = '0;
    row_mark = 1'b0;
    mid_clear_done = 1'b0;

    // Directed: never-counted index, saturation, invalid count, ignored
    // row_last on count, unused code, singleton, flag carried across a row,
    // clear, back-to-back counts and a check right behind a count.
    push_entry(sif_pkg::OP_CHECK, 20'h00000, 1'b0, 1'b1);
    push_entry(sif_pkg::OP_COUNT, 20'h00000, 1'b0, 1'b0);
    push_entry(sif_pkg::OP_COUNT, 20'hFFFFF, 1'b0, 1'b0);
    push_entry(sif_pkg::OP_COUNT, 20'hFFFFF, 1'b0, 1'b0);
    push_entry(sif_pkg::OP_COUNT, 20'hFFFFF, 1'b0, 1'b0);
    push_entry(sif_pkg::OP_COUNT, 20'h12345, 1'b1, 1'b0);
    push_entry(sif_pkg::OP_COUNT, 20'h00000, 1'b0, 1'b1);
    push_entry(sif_pkg::OP_COUNT, 20'h5A5A5, 1'b0, 1'b0);
    push_entry(OP_UNUSED, 20'h5A5A5, 1'b1, 1'b1);
    push_entry(sif_pkg::OP_CHECK, 20'hFFFFF, 1'b0, 1'b0);
    push_entry(sif_pkg::OP_CHECK, 20'h00000, 1'b0, 1'b1);
    push_entry(sif_pkg::OP_CHECK, 20'h5A5A5, 1'b0, 1'b1);
    push_entry(sif_pkg::OP_CHECK, 20'h12345, 1'b0, 1'b1);
    push_entry(sif_pkg::OP_CHECK, 20'h12345, 1'b1, 1'b0);
    push_entry(sif_pkg::OP_CHECK, 20'hFFFFF, 1'b0, 1'b1);
    push_entry(sif_pkg::OP_CHECK, 20'h5A5A5, 1'b0, 1'b0);
    push_entry(sif_pkg::OP_CHECK, 20'hFFFFF, 1'b0, 1'b1);
    push_entry(sif_pkg::OP_CLEAR, 20'hFFFFF, 1'b1, 1'b1);
    push_entry(sif_pkg::OP_CHECK, 20'h5A5A5, 1'b0, 1'b1);
    push_entry(sif_pkg::OP_COUNT, 20'hA5A5A, 1'b0, 1'b0);
    push_entry(sif_pkg::OP_COUNT, 20'hA5A5A, 1'b0, 1'b0);
    push_entry(sif_pkg::OP_COUNT, 20'h0000A, 1'b0, 1'b0);
    push_entry(sif_pkg::OP_CHECK, 20'hA5A5A, 1'b0, 1'b0);
    push_entry(sif_pkg::OP_CHECK, 20'h0000A, 1'b0, 1'b1);
    push_entry(sif_pkg::OP_COUNT, 20'h0000B, 1'b0, 1'b0);
    push_entry(sif_pkg::OP_CHECK, 20'h0000B, 1'b0, 1'b1);

    // Random: mostly well-formed passes, one clear partway through
    stim_items = 0;
    while (stim_items < RANDOM_ITEMS) begin
      if (!mid_clear_done && stim_items >= RANDOM_ITEMS / 2) begin
        push_entry(sif_pkg::OP_CLEAR, idx_t'($urandom), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
        mid_clear_done = 1'b1;
      end
      case ($urandom_range(0, 9))
        0, 1:    add_noise();
        2:       add_open_row();
        default: add_row_pass();
      endcase
    end

    // Reset once; the block then sweeps its table before taking entries
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (entry_queue.size() != 0 || in_valid_i) @(posedge clk_i);
    while (pending_rows.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (pending_rows.size() != 0) begin
      mismatches += pending_rows.size();
      $display("ERROR: %0d predicted rows never came out", pending_rows.size());
    end
    $display("Run covered %0d entries including %0d clears.", items_taken, clears_taken);
    $display("Checked %0d finished rows, %0d of them flagged for removal.",
             rows_seen, rows_removed);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog: three table sweeps plus the entries,
  // taken several times over
  initial begin
    #(64'd200_000_000);
    $display("Mismatches found");
    $finish;
  end

endmodule

@@ singleton_index_filter.f @@
design/sif_pkg.sv
design/sif_ram.sv
design/sif_sweep.sv
design/singleton_index_filter.sv
sim/tb_singleton_index_filter.sv
